### hdl/dtrtc_pkg.sv
package dtrtc_pkg;

  localparam int unsigned LINE_LEN  = 19;
  localparam int unsigned COUNT_MAX = 20;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SLASH = 8'd47;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_COLON = 8'd58;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  localparam logic [13:0] YEAR_MIN  = 14'd1900;
  localparam logic [13:0] YEAR_MAX  = 14'd2099;
  localparam logic [13:0] YEAR_2000 = 14'd2000;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FORMAT = 2'd1,
    STATUS_RANGE  = 2'd2
  } status_t;

  typedef struct packed {
    logic [4:0]  count;
    logic        format_ok;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [13:0] year;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } fields_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] seconds_bcd;
    logic [6:0] minutes_bcd;
    logic [5:0] hours_bcd;
    logic [5:0] days_bcd;
    logic       weekday_code;
    logic [7:0] month_century_bcd;
    logic [7:0] year_bcd;
  } result_t;

endpackage

### hdl/dtrtc_char_parser.sv
module dtrtc_char_parser
  import dtrtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] code,
  output fields_t    fields
);

  localparam fields_t FIELDS_IDLE = '{count: 5'd0, format_ok: 1'b1, day: 7'd0, month: 7'd0,
                                      year: 14'd0, hour: 7'd0, minute: 7'd0, second: 7'd0};

  fields_t st, st_next;

  logic       digit;
  logic [3:0] dval;
  logic [7:0] sep;
  logic       sep_pos;

  function automatic logic [6:0] acc7(input logic [6:0] old, input logic [3:0] d);
    logic [6:0] t;
    t = 7'((old << 3) + (old << 1));
    return 7'(t + 7'(d));
  endfunction

  function automatic logic [13:0] acc14(input logic [13:0] old, input logic [3:0] d);
    logic [13:0] t;
    t = 14'((old << 3) + (old << 1));
    return 14'(t + 14'(d));
  endfunction

  assign digit = (code >= CHAR_ZERO) && (code <= CHAR_NINE);
  assign dval  = code[3:0];

  always_comb begin
    sep     = 8'd0;
    sep_pos = 1'b1;
    unique case (st.count)
      5'd2, 5'd5:   sep = CHAR_SLASH;
      5'd10:        sep = CHAR_SPACE;
      5'd13, 5'd16: sep = CHAR_COLON;
      default:      sep_pos = 1'b0;
    endcase
  end

  always_comb begin
    st_next = st;
    if (fire) begin
      if (code == CHAR_CR) begin
        st_next = FIELDS_IDLE;
      end else begin
        if (st.count < 5'(LINE_LEN)) begin
          if (sep_pos) begin
            if (code != sep) st_next.format_ok = 1'b0;
          end else if (!digit) begin
            st_next.format_ok = 1'b0;
          end else if (st.count <= 5'd1) begin
            st_next.day = acc7(st.day, dval);
          end else if (st.count <= 5'd4) begin
            st_next.month = acc7(st.month, dval);
          end else if (st.count <= 5'd9) begin
            st_next.year = acc14(st.year, dval);
          end else if (st.count <= 5'd12) begin
            st_next.hour = acc7(st.hour, dval);
          end else if (st.count <= 5'd15) begin
            st_next.minute = acc7(st.minute, dval);
          end else begin
            st_next.second = acc7(st.second, dval);
          end
        end
        if (st.count < 5'(COUNT_MAX)) st_next.count = st.count + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= FIELDS_IDLE;
    end else begin
      st <= st_next;
    end
  end

  assign fields = st;

endmodule

### hdl/dtrtc_result_encoder.sv
module dtrtc_result_encoder
  import dtrtc_pkg::*;
(
  input  fields_t fields,
  output result_t result
);

  logic        time_ok, year_ok, day_ok, month_ok, leap, cal_ok, fmt_ok;
  logic        century;
  logic [13:0] yoff;
  logic [6:0]  yy;
  logic [4:0]  mlen;
  logic [7:0]  sec_b, min_b, hour_b, day_b, mon_b;

  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [17:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    p    = 18'(v) * 18'd205;
    tens = p[14:11];
    ones = 7'(v - 7'(tens * 4'd10));
    return {tens, ones[3:0]};
  endfunction

  always_comb begin
    unique case (fields.month[3:0])
      4'd2:                      mlen = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   mlen = 5'd30;
      default:                   mlen = 5'd31;
    endcase
  end

  assign fmt_ok   = (fields.count == 5'(LINE_LEN)) && fields.format_ok;
  assign time_ok  = (fields.second <= 7'd59) && (fields.minute <= 7'd59)
                  && (fields.hour <= 7'd23);
  assign year_ok  = (fields.year >= YEAR_MIN) && (fields.year <= YEAR_MAX);
  assign day_ok   = (fields.day >= 7'd1) && (fields.day <= 7'd31);
  assign month_ok = (fields.month >= 7'd1) && (fields.month <= 7'd12);
  // inside 1900..2099 only 1900 breaks the divisible-by-4 rule
  assign leap     = (fields.year[1:0] == 2'b00) && (fields.year != YEAR_MIN);
  assign cal_ok   = (leap && fields.month == 7'd2) ? (fields.day <= 7'd29)
                  : (month_ok && (fields.day <= 7'(mlen)));
  assign century  = fields.year >= YEAR_2000;
  assign yoff     = century ? fields.year - YEAR_2000 : fields.year - YEAR_MIN;
  assign yy       = yoff[6:0];

  assign sec_b  = to_bcd(fields.second);
  assign min_b  = to_bcd(fields.minute);
  assign hour_b = to_bcd(fields.hour);
  assign day_b  = to_bcd(fields.day);
  assign mon_b  = to_bcd(fields.month);

  always_comb begin
    result = '0;
    if (!fmt_ok) begin
      result.status = STATUS_FORMAT;
    end else if (!(time_ok && year_ok && day_ok && cal_ok)) begin
      result.status = STATUS_RANGE;
    end else begin
      result.status            = STATUS_OK;
      result.seconds_bcd       = {1'b1, sec_b[6:0]};
      result.minutes_bcd       = min_b[6:0];
      result.hours_bcd         = hour_b[5:0];
      result.days_bcd          = day_b[5:0];
      result.weekday_code      = 1'b0;
      result.month_century_bcd = {century, 2'b00, mon_b[4:0]};
      result.year_bcd          = to_bcd(yy);
    end
  end

endmodule

### hdl/datetime_text_to_rtc_bcd_top.sv
// Parses a DD/MM/YYYY HH:mm:ss text line, one ASCII character per item, and
// on carriage return delivers one result: status (0 valid, 1 format error,
// 2 range error) and the RTC register bytes in BCD, all zero on error. The
// block takes one character per cycle: an input register feeds a
// check-and-accumulate stage, and the carriage return loads a result register
// that holds while the consumer stalls. An accepted carriage return goes
// through the input register, then sets result_valid; only a carriage
// return meeting a full, stalled result register holds up the input.
module datetime_text_to_rtc_bcd_top
  import dtrtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_code,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [1:0] status,
  output logic [7:0] seconds_bcd,
  output logic [6:0] minutes_bcd,
  output logic [5:0] hours_bcd,
  output logic [5:0] days_bcd,
  output logic       weekday_code,
  output logic [7:0] month_century_bcd,
  output logic [7:0] year_bcd
);

  logic       char_vld;
  logic [7:0] char_q;
  logic       is_cr, slot_free, advance, fire;
  fields_t    fields;
  result_t    res_next, res_q;

  assign is_cr      = char_q == CHAR_CR;
  assign slot_free  = !result_valid || result_ready;
  assign advance    = !char_vld || !is_cr || slot_free;
  assign fire       = char_vld && advance;
  assign char_ready = !char_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_vld <= 1'b0;
    end else if (char_ready) begin
      char_vld <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) char_q <= char_code;
  end

  dtrtc_char_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .code   (char_q),
    .fields (fields)
  );

  dtrtc_result_encoder u_encoder (
    .fields (fields),
    .result (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && is_cr) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_cr) res_q <= res_next;
  end

  assign status            = res_q.status;
  assign seconds_bcd       = res_q.seconds_bcd;
  assign minutes_bcd       = res_q.minutes_bcd;
  assign hours_bcd         = res_q.hours_bcd;
  assign days_bcd          = res_q.days_bcd;
  assign weekday_code      = res_q.weekday_code;
  assign month_century_bcd = res_q.month_century_bcd;
  assign year_bcd          = res_q.year_bcd;

endmodule

### hdl/dtrtc_checker.sv
module dtrtc_checker
  import dtrtc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic [1:0] status,
  input logic [7:0] seconds_bcd,
  input logic [6:0] minutes_bcd,
  input logic [5:0] hours_bcd,
  input logic [5:0] days_bcd,
  input logic       weekday_code,
  input logic [7:0] month_century_bcd,
  input logic [7:0] year_bcd
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(status)
      && $stable(year_bcd) && $stable(seconds_bcd))
    else $error("stalled result item changed");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != STATUS_OK |-> seconds_bcd == 8'd0
      && minutes_bcd == 7'd0 && hours_bcd == 6'd0 && days_bcd == 6'd0
      && month_century_bcd == 8'd0 && year_bcd == 8'd0)
    else $error("error item carries nonzero bytes");

  a_ok_bytes: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == STATUS_OK |-> seconds_bcd[7] && !weekday_code
      && month_century_bcd[6:5] == 2'b00 && days_bcd != 6'd0)
    else $error("valid item has malformed bytes");

  a_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status == STATUS_OK || status == STATUS_FORMAT
      || status == STATUS_RANGE)
    else $error("bad status code");

endmodule

bind datetime_text_to_rtc_bcd_top dtrtc_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .result_valid      (result_valid),
  .result_ready      (result_ready),
  .status            (status),
  .seconds_bcd       (seconds_bcd),
  .minutes_bcd       (minutes_bcd),
  .hours_bcd         (hours_bcd),
  .days_bcd          (days_bcd),
  .weekday_code      (weekday_code),
  .month_century_bcd (month_century_bcd),
  .year_bcd          (year_bcd)
);

### tb/sv/datetime_text_to_rtc_bcd_top_test.sv
`timescale 1ns / 100ps

module datetime_text_to_rtc_bcd_top_test;
  import dtrtc_pkg::*;

  typedef struct {
    logic [7:0] code;
    bit         hold;
  } char_item_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_ready;
  logic [7:0] char_code = 8'd0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [1:0] status;
  logic [7:0] seconds_bcd;
  logic [6:0] minutes_bcd;
  logic [5:0] hours_bcd;
  logic [5:0] days_bcd;
  logic       weekday_code;
  logic [7:0] month_century_bcd;
  logic [7:0] year_bcd;

  char_item_t pending_chars[$];
  result_t    rtc_expected[$];
  fields_t    line_st;
  bit         hold_next = 1'b0;

  int mismatch_count = 0;
  int chars_sent = 0;
  int lines_ok = 0;
  int lines_fmt = 0;
  int lines_rng = 0;
  int burst_left = 1;
  int gap_left = 0;
  int ready_left = 0;
  bit ready_next = 1'b0;

  datetime_text_to_rtc_bcd_top u_dut (
    .clk               (clk),
    .rst               (rst),
    .char_valid        (char_valid),
    .char_ready        (char_ready),
    .char_code         (char_code),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .status            (status),
    .seconds_bcd       (seconds_bcd),
    .minutes_bcd       (minutes_bcd),
    .hours_bcd         (hours_bcd),
    .days_bcd          (days_bcd),
    .weekday_code      (weekday_code),
    .month_century_bcd (month_century_bcd),
    .year_bcd          (year_bcd)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // line parser prediction
  // ---------------------------------------------------------------------------
  function automatic fields_t idle_line();
    fields_t f;
    f = '0;
    f.format_ok = 1'b1;
    return f;
  endfunction

  function automatic logic [7:0] bcd2(input int unsigned v);
    v = v % 100;
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic bit date_in_range(input fields_t f);
    int unsigned y;
    int unsigned mlen[12];
    bit leap;
    y = f.year;
    mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (f.second > 59 || f.minute > 59 || f.hour > 23) return 1'b0;
    if (y > YEAR_MAX || y < YEAR_MIN) return 1'b0;
    if (f.day > 31 || f.day < 1) return 1'b0;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    if (leap && f.month == 2) return f.day <= 29;
    if (f.month > 12 || f.month < 1) return 1'b0;
    return f.day <= mlen[f.month - 1];
  endfunction

  task automatic parse_char(input logic [7:0] c);
    result_t     r;
    logic [7:0]  sep;
    int unsigned pos;
    int unsigned d;
    int unsigned y;
    bit          is_digit;
    bit          century;
    pos = line_st.count;
    if (c == CHAR_CR) begin
      r = '0;
      if (pos != LINE_LEN || !line_st.format_ok) begin
        r.status = STATUS_FORMAT;
      end else if (!date_in_range(line_st)) begin
        r.status = STATUS_RANGE;
      end else begin
        y = int'(line_st.year) - int'(YEAR_MIN);
        century = (y > 99);
        if (century) y = y - 100;
        r.status            = STATUS_OK;
        r.seconds_bcd       = (bcd2(line_st.second) & 8'h7F) | 8'h80;
        r.minutes_bcd       = 7'(bcd2(line_st.minute));
        r.hours_bcd         = 6'(bcd2(line_st.hour));
        r.days_bcd          = 6'(bcd2(line_st.day));
        r.weekday_code      = 1'b0;
        r.month_century_bcd = (bcd2(line_st.month) & 8'h1F) | (century ? 8'h80 : 8'h00);
        r.year_bcd          = bcd2(y);
      end
      rtc_expected.push_back(r);
      line_st = idle_line();
      return;
    end
    if (pos < LINE_LEN) begin
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d = is_digit ? int'(c) - int'(CHAR_ZERO) : 0;
      case (pos)
        2, 5:    sep = CHAR_SLASH;
        10:      sep = CHAR_SPACE;
        13, 16:  sep = CHAR_COLON;
        default: sep = 8'd0;
      endcase
      if (sep != 8'd0) begin
        if (c != sep) line_st.format_ok = 1'b0;
      end else if (!is_digit) begin
        line_st.format_ok = 1'b0;
      end else if (pos <= 1) begin
        line_st.day = 7'(int'(line_st.day) * 10 + d);
      end else if (pos <= 4) begin
        line_st.month = 7'(int'(line_st.month) * 10 + d);
      end else if (pos <= 9) begin
        line_st.year = 14'(int'(line_st.year) * 10 + d);
      end else if (pos <= 12) begin
        line_st.hour = 7'(int'(line_st.hour) * 10 + d);
      end else if (pos <= 15) begin
        line_st.minute = 7'(int'(line_st.minute) * 10 + d);
      end else begin
        line_st.second = 7'(int'(line_st.second) * 10 + d);
      end
    end
    if (line_st.count < COUNT_MAX) line_st.count = line_st.count + 1;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_char(input logic [7:0] c);
    char_item_t it;
    it.code = c;
    it.hold = hold_next;
    hold_next = 1'b0;
    pending_chars.push_back(it);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  task automatic queue_line(input string s);
    queue_text(s);
    queue_char(CHAR_CR);
  endtask

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 254));
    if (c >= CHAR_CR) c = c + 1;
    return c;
  endfunction

  function automatic int pick(input int lo, input int hi, input int wide);
    if ($urandom_range(0, 3) != 0) return $urandom_range(lo, hi);
    return $urandom_range(0, wide);
  endfunction

  function automatic string random_datetime();
    return $sformatf("%02d/%02d/%04d %02d:%02d:%02d",
                     pick(1, 31, 99), pick(1, 12, 99), pick(1900, 2099, 9999),
                     pick(0, 23, 99), pick(0, 59, 99), pick(0, 59, 99));
  endfunction

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      line_st = idle_line();
    end else begin
      if (char_valid && char_ready) begin
        parse_char(char_code);
        void'(pending_chars.pop_front());
        chars_sent++;
      end
      if (char_valid && !char_ready) begin
        // item held until accepted
      end else if (gap_left != 0) begin
        gap_left--;
        char_valid <= 1'b0;
      end else if (pending_chars.size() == 0 ||
                   (pending_chars[0].hold && rtc_expected.size() != 0)) begin
        char_valid <= 1'b0;
      end else begin
        pending_chars[0].hold = 1'b0;
        char_valid <= 1'b1;
        char_code  <= pending_chars[0].code;
        burst_left--;
        if (burst_left <= 0) begin
          gap_left = $urandom_range(0, 6);
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 10);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (rtc_expected.size() == 0) begin
          $error("result with no line pending: status %0d", status);
          mismatch_count++;
        end else begin
          want = rtc_expected.pop_front();
          case (want.status)
            STATUS_OK:     lines_ok++;
            STATUS_FORMAT: lines_fmt++;
            default:       lines_rng++;
          endcase
          check_field("status", want.status, status);
          check_field("seconds_bcd", want.seconds_bcd, seconds_bcd);
          check_field("minutes_bcd", want.minutes_bcd, minutes_bcd);
          check_field("hours_bcd", want.hours_bcd, hours_bcd);
          check_field("days_bcd", want.days_bcd, days_bcd);
          check_field("weekday_code", want.weekday_code, weekday_code);
          check_field("month_century_bcd", want.month_century_bcd, month_century_bcd);
          check_field("year_bcd", want.year_bcd, year_bcd);
        end
      end
      if (ready_left == 0) begin
        ready_next = ($urandom_range(0, 3) != 0);
        ready_left = ready_next ? $urandom_range(1, 30) : $urandom_range(1, 12);
      end
      ready_left--;
      result_ready <= ready_next;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int    kind;
    int    cut;
    int    bad;
    int    lines_made;
    string s;

    queue_line("01/01/1900 00:00:00");
    queue_line("31/12/2099 23:59:59");
    queue_line("");
    queue_line("29/02/2000 12:34:56");
    queue_line("29/02/1900 12:34:56");
    queue_line("29/02/2024 06:07:08");
    queue_line("29/02/2023 06:07:08");
    queue_line("30/04/2021 10:20:30");
    queue_line("31/04/2021 10:20:30");
    queue_line("00/05/2000 00:00:00");
    queue_line("32/01/2000 00:00:00");
    queue_line("15/13/2000 00:00:00");
    queue_line("15/00/2000 00:00:00");
    queue_line("01/01/1899 00:00:00");
    queue_line("01/01/2100 00:00:00");
    queue_line("01/01/2000 24:00:00");
    queue_line("01/01/2000 00:60:00");
    queue_line("01/01/2000 00:00:60");
    queue_line("99/99/9999 99:99:99");
    queue_line("99/99/9999 99:99:9x");
    queue_line("01/01/2000 00:00:0");
    queue_line("01/01/2000 00:00:000");
    queue_line("01-01-2000 00:00:00");
    queue_text("0");
    queue_char(8'hFF);
    queue_line("/01/2000 00:00:00");
    queue_text("01");
    queue_char(8'h00);
    queue_line("01/2000 00:00:00");
    queue_line("01/01/2000 00:00:00 trailing noise");

    hold_next = 1'b1;
    lines_made = 0;
    while (pending_chars.size() < 2000) begin
      lines_made++;
      if (lines_made % 37 == 0) hold_next = 1'b1;
      s = random_datetime();
      kind = $urandom_range(0, 19);
      if (kind <= 13) begin
        queue_line(s);
      end else if (kind <= 16) begin
        bad = $urandom_range(0, 18);
        for (int i = 0; i < 19; i++) queue_char((i == bad) ? noise_char() : s[i]);
        queue_char(CHAR_CR);
      end else if (kind == 17) begin
        cut = $urandom_range(0, 18);
        for (int i = 0; i < cut; i++) queue_char(s[i]);
        queue_char(CHAR_CR);
      end else if (kind == 18) begin
        queue_text(s);
        repeat ($urandom_range(1, 8)) queue_char(noise_char());
        queue_char(CHAR_CR);
      end else begin
        repeat ($urandom_range(0, 30)) queue_char(noise_char());
        queue_char(CHAR_CR);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || char_valid || rtc_expected.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d characters sent, %0d lines checked: %0d valid, %0d format errors, %0d range errors",
             chars_sent, lines_ok + lines_fmt + lines_rng, lines_ok, lines_fmt, lines_rng);
    if (mismatch_count == 0 && rtc_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule
